// ----- rtl/qpht_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants for the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;
	localparam int KEY_W = 64;
	localparam int CAP_W = 11;
	localparam int SLOT_COUNT = 1024;

	typedef enum logic [1:0] {
		OP_FIND     = 2'd0,
		OP_INSERT   = 2'd1,
		OP_DELETE   = 2'd2,
		OP_RETRIEVE = 2'd3
	} op_t;

	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_LIVE    = 2'd1;
	localparam logic [1:0] ST_DELETED = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture operands, clear hash
		logic hash_step;  // fold one key byte
		logic mod_init;   // start remainder of hash by capacity
		logic mod_step;   // one restoring step
		logic home_set;   // current = home, i = 0
		logic rd;         // issue slot read at current
		logic next_probe; // advance probe index
		logic wr;         // write slot
		logic wr_key;     // write key as well
		logic cnt_inc;
		logic cnt_dec;
		logic sel_ret;    // current = slot_index
		logic clr_st;     // clearing sweep write
		logic clr_adv;
		logic out_en;
	} qpht_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic hash_done;
		logic mod_done;
		logic hit;        // slot empty or key matches
		logic live;       // slot is live
		logic full;       // probe exhausted
		logic clr_last;
	} qpht_sts_t;
endpackage
`default_nettype wire

// ----- rtl/quadratic_probe_hash_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing key table with multiply-by-33 hashing and quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//  - Raise start with kind, key_text and slot_index while busy is low; the
//    command transfers on that edge and busy rises. Operands are captured.
//  - One result appears for exactly one cycle with done high: position,
//    found, status_code, key_out, slot_state, live_count. The receiver
//    cannot stall; take the result in that cycle.
//  - Find/insert/delete: hash the key bytes, take the remainder of the hash
//    by capacity (32 restoring steps), then home set, slot read, read wait
//    and check. Each further probe steps the index, then reads, waits and
//    checks again. Done rises once the check ends the probe, and the next
//    command can transfer at its end. A full table is reported as table
//    full once the probe has returned to the home slot twice.
//  - Retrieve: reads the slot at slot_index directly, with no hash or probe.
//  - The capacity register is written from cfg_data on cfg_valid && cfg_ready; write only idle.
//  - After reset the status store is swept empty, one slot per cycle, over
//    all SLOT_COUNT slots; busy stays high and no command transfers meanwhile.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
	parameter int KEY_CHARS  = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] key_text,
	input  wire logic [9:0]  slot_index,
	output logic             done,
	output logic [9:0]       position,
	output logic             found,
	output logic             status_code,
	output logic [63:0]      key_out,
	output logic [1:0]       slot_state,
	output logic [10:0]      live_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);
	import qpht_pkg::*;

	qpht_cmd_t cmd;
	qpht_sts_t sts;
	logic [10:0] cap_q;

	// capacity register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 11'd1024;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	qpht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind), .sts(sts), .cmd(cmd),
		.busy(busy), .done(done), .found(found), .status_code(status_code)
	);

	qpht_datapath #(.KEY_CHARS(KEY_CHARS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .key_text(key_text),
		.slot_index(slot_index), .cap_reg(cap_q), .position(position),
		.key_out(key_out), .slot_state(slot_state), .live_count(live_count)
	);
endmodule
`default_nettype wire

// ----- rtl/qpht_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/qpht_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_datapath
// Hash, modulo, probe arithmetic, slot stores and live count.
// ----------------------------------------------------------------------------
module qpht_datapath #(
	parameter int KEY_CHARS  = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire qpht_pkg::qpht_cmd_t       cmd,
	output qpht_pkg::qpht_sts_t            sts,
	input  wire logic [63:0]               key_text,
	input  wire logic [9:0]                slot_index,
	input  wire logic [10:0]               cap_reg,
	output logic [9:0]                     position,
	output logic [63:0]                    key_out,
	output logic [1:0]                     slot_state,
	output logic [10:0]                    live_count
);
	import qpht_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int CW = AW + 1;           // holds SLOT_COUNT itself
	localparam int BW = $clog2(KEY_CHARS + 1);

	logic [63:0]   raw_q;
	logic [63:0]   key_q;
	logic [31:0]   hash_q;
	logic [BW-1:0] byte_q;
	logic          ended_q;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] rem_q;
	logic [5:0]    mbit_q;
	logic [AW-1:0] home_q, cur_q, addr_q;
	logic [CW-1:0] step_q;     // (i*i) mod cap maintained incrementally
	logic [CW-1:0] odd_q;      // (2i+1) mod cap
	logic [1:0]    wraps_q;
	logic [CW-1:0] cnt_q;
	logic [AW:0]   clr_q;
	logic [7:0]    cbyte;

	logic [63:0] key_rd;
	logic [1:0]  st_rd;
	logic [1:0]  st_wd;
	logic [1:0]  st_wd_eff;
	logic        st_we;
	logic [AW-1:0] st_addr;
	logic [AW-1:0] ram_addr;

	// effective capacity clamp
	logic [CW-1:0] cap_eff;
	always_comb begin
		if (cap_reg == '0) begin
			cap_eff = CW'(1);
		end else if ({{(CW > 11 ? CW - 11 : 1){1'b0}}, cap_reg} > (CW+1)'(SLOT_COUNT)) begin
			cap_eff = CW'(SLOT_COUNT);
		end else begin
			cap_eff = CW'(cap_reg);
		end
	end

	assign cbyte = raw_q[8*byte_q +: 8];

	// add-mod helper: a,b < cap
	function automatic logic [CW-1:0] addm(input logic [CW-1:0] a, input logic [CW-1:0] b,
		input logic [CW-1:0] c);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, c}) s = s - {1'b0, c};
		return s[CW-1:0];
	endfunction

	logic [CW:0] rtry;
	assign rtry = {rem_q, hash_q[mbit_q[4:0]]} - {1'b0, cap_q};

	logic [CW-1:0] nstep, ncur;
	assign nstep = addm(step_q, odd_q, cap_q);
	assign ncur  = addm(CW'(home_q), nstep, cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (cmd.clr_adv) clr_q <= clr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q   <= key_text;
			hash_q  <= '0;
			key_q   <= '0;
			byte_q  <= '0;
			ended_q <= 1'b0;
			cap_q   <= cap_eff;
		end
		if (cmd.hash_step) begin
			if (!ended_q && cbyte != 8'd0) begin
				hash_q <= (hash_q << 5) + hash_q + 32'(cbyte);
				key_q[8*byte_q +: 8] <= cbyte;
			end else begin
				ended_q <= 1'b1;
			end
			byte_q <= byte_q + BW'(1);
		end
		if (cmd.mod_init) begin
			rem_q  <= '0;
			mbit_q <= 6'd31;
		end
		if (cmd.mod_step) begin
			if (!rtry[CW]) rem_q <= rtry[CW-1:0];
			else rem_q <= {rem_q[CW-2:0], hash_q[mbit_q[4:0]]};
			mbit_q <= mbit_q - 6'd1;
		end
		if (cmd.home_set) begin
			home_q  <= rem_q[AW-1:0];
			cur_q   <= rem_q[AW-1:0];
			step_q  <= '0;
			odd_q   <= (cap_q == CW'(1)) ? '0 : CW'(1);
			wraps_q <= '0;
		end
		if (cmd.next_probe) begin
			step_q <= nstep;
			odd_q  <= addm(odd_q, (cap_q <= CW'(2)) ? (CW'(2) - cap_q) : CW'(2), cap_q);
			cur_q  <= ncur[AW-1:0];
			if (ncur[AW-1:0] == home_q) wraps_q <= wraps_q + 2'd1;
		end
		if (cmd.sel_ret) cur_q <= slot_index[AW-1:0];
		if (cmd.rd || cmd.sel_ret) addr_q <= cmd.sel_ret ? slot_index[AW-1:0] : cur_q;
		if (cmd.out_en) begin
			position   <= 10'(addr_q);
			key_out    <= (st_wd_eff == ST_EMPTY) ? '0 : (cmd.wr_key ? key_q : key_rd);
			slot_state <= st_wd_eff;
			live_count <= 11'(cmd.cnt_inc ? cnt_q + CW'(1) : cmd.cnt_dec ? cnt_q - CW'(1) : cnt_q);
		end
	end

	assign st_wd_eff = cmd.wr ? (cmd.wr_key ? ST_LIVE : ST_DELETED) : st_rd;

	assign st_we   = cmd.wr || cmd.clr_st;
	assign st_wd   = cmd.clr_st ? ST_EMPTY : st_wd_eff;
	assign st_addr = cmd.clr_st ? clr_q[AW-1:0] : addr_q;

	// retrieve reads at the transfer edge, probes read at the current slot
	assign ram_addr = cmd.sel_ret ? slot_index[AW-1:0] : (cmd.rd ? cur_q : st_addr);

	qpht_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_status (
		.clk(clk), .we(st_we), .addr(ram_addr), .wdata(st_wd), .rdata(st_rd)
	);
	qpht_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_keys (
		.clk(clk), .we(cmd.wr && cmd.wr_key), .addr(ram_addr),
		.wdata(key_q), .rdata(key_rd)
	);

	always_comb begin
		sts.hash_done = (byte_q == BW'(KEY_CHARS));
		sts.mod_done  = (mbit_q == 6'h3f);
		sts.hit       = (st_rd == ST_EMPTY) || (key_rd == key_q);
		sts.live      = (st_rd == ST_LIVE);
		sts.full      = (wraps_q > 2'd1);
		sts.clr_last  = (clr_q[AW-1:0] == AW'(SLOT_COUNT - 1));
	end
endmodule
`default_nettype wire

// ----- rtl/qpht_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ctrl
// Sequencer for the reset sweep, hash, modulo, probe, update and retrieve.
// ----------------------------------------------------------------------------
module qpht_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           kind,
	input  wire qpht_pkg::qpht_sts_t  sts,
	output qpht_pkg::qpht_cmd_t       cmd,
	output logic                      busy,
	output logic                      done,
	output logic                      found,
	output logic                      status_code
);
	import qpht_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_HASH  = 10'b0000000100,
		S_MOD   = 10'b0000001000,
		S_HOME  = 10'b0000010000,
		S_READ  = 10'b0000100000,
		S_WAIT  = 10'b0001000000,
		S_CHECK = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_RET   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	op_t    op_q;
	logic   found_d, full_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			op_q        <= OP_FIND;
			done        <= 1'b0;
			found       <= 1'b0;
			status_code <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && !busy) op_q <= op_t'(kind);
			done <= cmd.out_en;
			if (cmd.out_en) begin
				found       <= found_d;
				status_code <= full_d;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		found_d = 1'b0;
		full_d  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_st  = 1'b1;
				cmd.clr_adv = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (op_t'(kind) == OP_RETRIEVE) begin
						cmd.sel_ret = 1'b1;
						state_d = S_RET;
					end else begin
						state_d = S_HASH;
					end
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				cmd.mod_init  = 1'b1;
				if (sts.hash_done) begin
					cmd.hash_step = 1'b0;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					cmd.mod_step = 1'b0;
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.home_set = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.rd = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				// on exhaustion the slot just read is the home slot
				if (sts.full) begin
					full_d     = 1'b1;
					cmd.out_en = 1'b1;
					state_d    = S_IDLE;
				end else if (sts.hit) begin
					found_d    = sts.live;
					cmd.out_en = 1'b1;
					if (op_q == OP_INSERT && !sts.live) begin
						cmd.wr = 1'b1; cmd.wr_key = 1'b1; cmd.cnt_inc = 1'b1;
					end else if (op_q == OP_DELETE && sts.live) begin
						cmd.wr = 1'b1; cmd.cnt_dec = 1'b1;
					end
					state_d = S_IDLE;
				end else begin
					cmd.next_probe = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// read the new slot; exhaustion is reported after the home slot is read
				cmd.rd  = 1'b1;
				state_d = S_WAIT;
			end
			S_RET: begin
				// slot data arrives this cycle
				found_d    = sts.live;
				cmd.out_en = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
